>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCDAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BCDAU_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BCDAU_ASSERT(lbl, prop, msg)
`define BCDAU_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/bcdau_pkg.sv
// ----------------------------------------------------------------------------
// bcdau_pkg
// Types, codes and constants of the packed BCD arithmetic unit.
// ----------------------------------------------------------------------------
package bcdau_pkg;

    // width of a binary value below 10^8
    localparam int VAL_W = 27;

    typedef enum logic [2:0] {
        OP_CHECK = 3'd0,
        OP_B2BCD = 3'd1,
        OP_BCD2B = 3'd2,
        OP_ADD   = 3'd3,
        OP_SUB   = 3'd4,
        OP_MUL   = 3'd5,
        OP_DIV   = 3'd6,
        OP_MOD   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_DIGIT = 3'd1,
        ERR_RANGE = 3'd2,
        ERR_UNDER = 3'd3,
        ERR_OVER  = 3'd4,
        ERR_DIVZ  = 3'd5
    } err_t;

    // weights of the eight nibbles
    localparam logic [VAL_W-1:0] POW10 [8] = '{
        27'd1, 27'd10, 27'd100, 27'd1000,
        27'd10000, 27'd100000, 27'd1000000, 27'd10000000
    };

    // request travelling down the cell chains
    typedef struct packed {
        op_t               op;
        err_t              err;
        logic              done;     // result already final in res
        logic [31:0]       res;
        logic [31:0]       divisor;
        logic [VAL_W-1:0]  num;      // dividend / quotient, then value to convert
        logic [VAL_W-1:0]  rem;
        logic [31:0]       bcd;
    } pipe_t;

    function automatic int clamp_digits(input int d);
        int r;
        r = d;
        if (r < 1) r = 1;
        if (r > 8) r = 8;
        return r;
    endfunction

    function automatic logic [31:0] max_value(input int d);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 0; i < d; i++) p = p * 32'd10;
        return p - 32'd1;
    endfunction

endpackage

>>> rtl/core/bcdau_div_cell.sv
// ----------------------------------------------------------------------------
// bcdau_div_cell
// One restoring division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module bcdau_div_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcdau_pkg::pipe_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bcdau_pkg::pipe_t   out_data
);

    logic               valid_reg;
    bcdau_pkg::pipe_t   data_reg;
    bcdau_pkg::pipe_t   data_next;
    logic [bcdau_pkg::VAL_W:0] trial;
    logic               active;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        data_next = in_data;
        active = !in_data.done &&
                 (in_data.op == bcdau_pkg::OP_DIV || in_data.op == bcdau_pkg::OP_MOD);
        trial  = {in_data.rem, in_data.num[bcdau_pkg::VAL_W-1]};
        if (active)
        begin
            if ({{(31-bcdau_pkg::VAL_W){1'b0}}, trial} >= in_data.divisor)
            begin
                data_next.rem = bcdau_pkg::VAL_W'(
                    {{(31-bcdau_pkg::VAL_W){1'b0}}, trial} - in_data.divisor);
                data_next.num = {in_data.num[bcdau_pkg::VAL_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = trial[bcdau_pkg::VAL_W-1:0];
                data_next.num = {in_data.num[bcdau_pkg::VAL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

>>> rtl/core/bcdau_dd_cell.sv
// ----------------------------------------------------------------------------
// bcdau_dd_cell
// One double-dabble step: add-3 correction on each digit, then shift a bit in.
// ----------------------------------------------------------------------------
module bcdau_dd_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcdau_pkg::pipe_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bcdau_pkg::pipe_t   out_data
);

    logic               valid_reg;
    bcdau_pkg::pipe_t   data_reg;
    bcdau_pkg::pipe_t   data_next;
    logic [31:0]        adj;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // correct digits at or above five, then shift in the next binary bit
    always_comb
    begin
        data_next = in_data;
        adj = in_data.bcd;
        for (int j = 0; j < 8; j++)
        begin
            if (in_data.bcd[4*j +: 4] >= 4'd5)
                adj[4*j +: 4] = in_data.bcd[4*j +: 4] + 4'd3;
        end
        if (!in_data.done)
        begin
            data_next.bcd = {adj[30:0], in_data.num[bcdau_pkg::VAL_W-1]};
            data_next.num = {in_data.num[bcdau_pkg::VAL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

>>> rtl/core/packed_bcd_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// packed_bcd_arithmetic_unit
// Eight-digit packed BCD check, conversion and arithmetic unit.
// ----------------------------------------------------------------------------
// One request per cycle is taken while the output is not stalled, and each
// gives one result after passing four front stages (digit check and BCD to
// binary, sum, add/subtract/multiply, range decision), a chain of 27
// division cells producing one quotient bit each, and a chain of 27
// double-dabble cells turning the 27-bit binary value into BCD one bit each.
// Every stage holds its own request, so bubbles close up while the output
// is stalled and new requests keep entering until the chain is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_bcd_arithmetic_unit
#(
    parameter int DIGIT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] bcd_word,
    input  logic [31:0] binary_operand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_word,
    output logic [2:0]  error_code
);

    localparam int VW  = bcdau_pkg::VAL_W;
    localparam int EFF = bcdau_pkg::clamp_digits(DIGIT_COUNT);
    localparam logic [VW-1:0] LIM = VW'(bcdau_pkg::max_value(EFF));

    // front stage registers
    logic               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic               s1_ready, s2_ready, s3_ready, s4_ready;
    bcdau_pkg::op_t     s1_op_reg, s2_op_reg, s3_op_reg;
    logic [31:0]        s1_w_reg, s2_w_reg, s3_w_reg;
    logic [31:0]        s1_b_reg, s2_b_reg, s3_b_reg;
    logic               s1_ok_reg, s2_ok_reg, s3_ok_reg;
    logic               s1_ok_next;
    logic [VW-1:0]      s1_p_reg [4];
    logic [VW-1:0]      s1_p_next [4];
    logic [VW-1:0]      s2_v_val_reg, s3_v_val_reg;
    logic [32:0]        s3_sum_reg;
    logic [VW+31:0]     s3_prod_reg;
    bcdau_pkg::pipe_t   s4_data_reg, s4_data_next;

    // cell chains
    logic               dv_valid [VW+1];
    logic               dv_ready [VW+1];
    bcdau_pkg::pipe_t   dv_data  [VW+1];
    logic               dd_valid [VW+1];
    logic               dd_ready [VW+1];
    bcdau_pkg::pipe_t   dd_data  [VW+1];

    // stage hand-off
    assign s1_ready = !s1_v_reg || s2_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s3_ready = !s3_v_reg || s4_ready;
    assign s4_ready = !s4_v_reg || dv_ready[0];
    assign in_stall = !s1_ready;

    // digit check and weighted nibble pairs
    always_comb
    begin
        s1_ok_next = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (i < EFF)
            begin
                if (bcd_word[4*i +: 4] > 4'd9) s1_ok_next = 1'b0;
            end
            else if (bcd_word[4*i +: 4] != 4'd0)
                s1_ok_next = 1'b0;
        end
        for (int k = 0; k < 4; k++)
        begin
            s1_p_next[k] = VW'(bcd_word[8*k +: 4]) * bcdau_pkg::POW10[2*k]
                         + VW'(bcd_word[8*k+4 +: 4]) * bcdau_pkg::POW10[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_v_reg <= in_valid;
            if (s2_ready) s2_v_reg <= s1_v_reg;
            if (s3_ready) s3_v_reg <= s2_v_reg;
            if (s4_ready) s4_v_reg <= s3_v_reg;
        end
    end

    // front pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_op_reg <= bcdau_pkg::op_t'(op);
            s1_w_reg  <= bcd_word;
            s1_b_reg  <= binary_operand;
            s1_ok_reg <= s1_ok_next;
            s1_p_reg  <= s1_p_next;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_op_reg    <= s1_op_reg;
            s2_w_reg     <= s1_w_reg;
            s2_b_reg     <= s1_b_reg;
            s2_ok_reg    <= s1_ok_reg;
            s2_v_val_reg <= s1_p_reg[0] + s1_p_reg[1] + s1_p_reg[2] + s1_p_reg[3];
        end
        if (s3_ready && s2_v_reg)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_w_reg     <= s2_w_reg;
            s3_b_reg     <= s2_b_reg;
            s3_ok_reg    <= s2_ok_reg;
            s3_v_val_reg <= s2_v_val_reg;
            s3_sum_reg   <= {6'd0, s2_v_val_reg} + {1'b0, s2_b_reg};
            s3_prod_reg  <= {32'd0, s2_v_val_reg} * {{VW{1'b0}}, s2_b_reg};
        end
        if (s4_ready && s3_v_reg)
            s4_data_reg <= s4_data_next;
    end

    // decide errors and the value to carry into the chains
    always_comb
    begin
        s4_data_next         = '0;
        s4_data_next.op      = s3_op_reg;
        s4_data_next.err     = bcdau_pkg::ERR_NONE;
        s4_data_next.done    = 1'b1;
        s4_data_next.res     = s3_w_reg;
        s4_data_next.divisor = s3_b_reg;
        case (s3_op_reg)
            bcdau_pkg::OP_CHECK:
            begin
                if (!s3_ok_reg) s4_data_next.err = bcdau_pkg::ERR_DIGIT;
            end
            bcdau_pkg::OP_B2BCD:
            begin
                if (s3_b_reg <= {{(32-VW){1'b0}}, LIM})
                begin
                    s4_data_next.done = 1'b0;
                    s4_data_next.num  = s3_b_reg[VW-1:0];
                end
                else
                begin
                    s4_data_next.res = s3_b_reg;
                    s4_data_next.err = bcdau_pkg::ERR_RANGE;
                end
            end
            bcdau_pkg::OP_BCD2B:
            begin
                if (s3_ok_reg) s4_data_next.res = {{(32-VW){1'b0}}, s3_v_val_reg};
                else           s4_data_next.err = bcdau_pkg::ERR_DIGIT;
            end
            default:
            begin
                if (s3_op_reg == bcdau_pkg::OP_DIV && s3_b_reg == 32'd0)
                    s4_data_next.err = bcdau_pkg::ERR_DIVZ;
                else if (!s3_ok_reg)
                    s4_data_next.err = bcdau_pkg::ERR_DIGIT;
                else if (s3_op_reg == bcdau_pkg::OP_ADD)
                begin
                    if (s3_sum_reg > {{(33-VW){1'b0}}, LIM})
                        s4_data_next.err = bcdau_pkg::ERR_OVER;
                    else
                    begin
                        s4_data_next.done = 1'b0;
                        s4_data_next.num  = s3_sum_reg[VW-1:0];
                    end
                end
                else if (s3_op_reg == bcdau_pkg::OP_SUB)
                begin
                    if ({{(32-VW){1'b0}}, s3_v_val_reg} < s3_b_reg)
                        s4_data_next.err = bcdau_pkg::ERR_UNDER;
                    else
                    begin
                        s4_data_next.done = 1'b0;
                        s4_data_next.num  = s3_v_val_reg - s3_b_reg[VW-1:0];
                    end
                end
                else if (s3_op_reg == bcdau_pkg::OP_MUL)
                begin
                    if (s3_prod_reg > {32'd0, LIM})
                        s4_data_next.err = bcdau_pkg::ERR_OVER;
                    else
                    begin
                        s4_data_next.done = 1'b0;
                        s4_data_next.num  = s3_prod_reg[VW-1:0];
                    end
                end
                else if (s3_op_reg == bcdau_pkg::OP_MOD && s3_b_reg == 32'd0)
                    s4_data_next.err = bcdau_pkg::ERR_DIVZ;
                else
                begin
                    s4_data_next.done = 1'b0;
                    s4_data_next.num  = s3_v_val_reg;
                end
            end
        endcase
    end

    // division chain
    assign dv_valid[0] = s4_v_reg;
    assign dv_data[0]  = s4_data_reg;

    for (genvar i = 0; i < VW; i++)
    begin : g_div
        bcdau_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    // modulo converts the remainder, everything else the carried value
    assign dv_ready[VW] = dd_ready[0];
    assign dd_valid[0]  = dv_valid[VW];
    always_comb
    begin
        dd_data[0] = dv_data[VW];
        if (dv_data[VW].op == bcdau_pkg::OP_MOD)
            dd_data[0].num = dv_data[VW].rem;
        dd_data[0].bcd = '0;
    end

    // binary to BCD chain
    for (genvar i = 0; i < VW; i++)
    begin : g_dd
        bcdau_dd_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dd_valid[i]),
            .in_ready  (dd_ready[i]),
            .in_data   (dd_data[i]),
            .out_valid (dd_valid[i+1]),
            .out_ready (dd_ready[i+1]),
            .out_data  (dd_data[i+1])
        );
    end

    // output
    assign dd_ready[VW] = !out_stall;
    assign out_valid    = dd_valid[VW];
    assign result_word  = dd_data[VW].done ? dd_data[VW].res : dd_data[VW].bcd;
    assign error_code   = dd_data[VW].err;

    // checks
    `BCDAU_ASSERT(a_val_in_range,
        (s4_v_reg && !s4_data_reg.done) |-> (s4_data_reg.num <= LIM),
        "value to convert exceeds the digit range")
    `BCDAU_ASSERT(a_rem_below_div,
        (dv_valid[VW] && !dv_data[VW].done &&
         (dv_data[VW].op == bcdau_pkg::OP_DIV || dv_data[VW].op == bcdau_pkg::OP_MOD))
        |-> ({{(32-VW){1'b0}}, dv_data[VW].rem} < dv_data[VW].divisor),
        "division remainder not below divisor")
    `BCDAU_NEVER(a_conv_no_err,
        out_valid && !dd_data[VW].done && (dd_data[VW].err != bcdau_pkg::ERR_NONE),
        "converted result carries an error code")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Packed BCD arithmetic unit testbench
// Drives directed and random requests through the unit under three idling
// phases and checks every result against a behavioural predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_RANDOM  = 1030;
    localparam int LIMIT_CYC = 400000;
    localparam int LATENCY   = 58;

    typedef struct {
        logic [31:0]       word;
        bcdau_pkg::err_t   err;
    } bcd_result_t;

    typedef struct {
        bcdau_pkg::op_t    op;
        logic [31:0]       bcd;
        logic [31:0]       bin;
        logic              typed;   // expected result given in the row
        logic [31:0]       xword;
        bcdau_pkg::err_t   xerr;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [31:0] bcd_word;
    logic [31:0] binary_operand;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result_word;
    logic [2:0]  error_code;

    bcd_result_t expected_results[$];
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    packed_bcd_arithmetic_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .bcd_word       (bcd_word),
        .binary_operand (binary_operand),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_word    (result_word),
        .error_code     (error_code)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // every nibble a decimal digit
    function automatic bit digits_ok(input logic [31:0] w);
        for (int i = 0; i < 8; i++)
            if (w[4*i +: 4] > 4'd9)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] decode_bcd(input logic [31:0] w);
        logic [63:0] acc;
        acc = 64'd0;
        for (int i = 7; i >= 0; i--)
            acc = acc * 64'd10 + 64'(w[4*i +: 4]);
        return acc;
    endfunction

    function automatic logic [31:0] encode_bcd(input logic [63:0] v);
        logic [31:0] w;
        w = 32'd0;
        for (int i = 0; i < 8; i++)
        begin
            w[4*i +: 4] = 4'(v % 64'd10);
            v = v / 64'd10;
        end
        return w;
    endfunction

    // predicted result of one request
    function automatic bcd_result_t predict_bcd_op(input bcdau_pkg::op_t o,
                                                   input logic [31:0] w,
                                                   input logic [31:0] b);
        bcd_result_t r;
        logic [63:0] v;
        logic [63:0] top;
        top = 64'd99999999;
        r.word = w;
        r.err  = bcdau_pkg::ERR_NONE;
        case (o)
            bcdau_pkg::OP_CHECK: if (!digits_ok(w)) r.err = bcdau_pkg::ERR_DIGIT;
            bcdau_pkg::OP_B2BCD:
                if (64'(b) <= top) r.word = encode_bcd(64'(b));
                else
                begin
                    r.word = b;
                    r.err  = bcdau_pkg::ERR_RANGE;
                end
            bcdau_pkg::OP_BCD2B:
                if (digits_ok(w)) r.word = 32'(decode_bcd(w));
                else r.err = bcdau_pkg::ERR_DIGIT;
            default:
            begin
                if (o == bcdau_pkg::OP_DIV && b == 32'd0) r.err = bcdau_pkg::ERR_DIVZ;
                else if (!digits_ok(w)) r.err = bcdau_pkg::ERR_DIGIT;
                else
                begin
                    v = decode_bcd(w);
                    case (o)
                        bcdau_pkg::OP_ADD: v = v + 64'(b);
                        bcdau_pkg::OP_SUB:
                            if (v < 64'(b)) r.err = bcdau_pkg::ERR_UNDER;
                            else v = v - 64'(b);
                        bcdau_pkg::OP_MUL: v = v * 64'(b);
                        bcdau_pkg::OP_DIV: v = v / 64'(b);
                        default:
                            if (b == 32'd0) r.err = bcdau_pkg::ERR_DIVZ;
                            else v = v % 64'(b);
                    endcase
                    if (r.err == bcdau_pkg::ERR_NONE &&
                        (o == bcdau_pkg::OP_ADD || o == bcdau_pkg::OP_MUL) && v > top)
                        r.err = bcdau_pkg::ERR_OVER;
                    if (r.err == bcdau_pkg::ERR_NONE)
                        r.word = encode_bcd(v);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_bcd(input int ndig);
        logic [31:0] w;
        w = 32'd0;
        for (int i = 0; i < ndig; i++)
            w[4*i +: 4] = 4'($urandom_range(9));
        return w;
    endfunction

    // one request offered until accepted; valid stays up for the next one
    task automatic send_request(input bcdau_pkg::op_t o, input logic [31:0] w,
                                input logic [31:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        bcd_word       <= w;
        binary_operand <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_bcd_op(o, w, b));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end

    // result checking
    always @(posedge clk)
    begin
        bcd_result_t x;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h err %0d", $time, result_word,
                         error_code);
                fail_count++;
            end
            else
            begin
                x = expected_results.pop_front();
                if (result_word !== x.word)
                begin
                    $display("%0t: result_word expected %h actual %h", $time, x.word,
                             result_word);
                    fail_count++;
                end
                if (error_code !== x.err)
                begin
                    $display("%0t: error_code expected %0d actual %0d", $time, x.err,
                             error_code);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYC)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    stim_row_t rows[$];

    task automatic add_row(input bcdau_pkg::op_t o, input logic [31:0] w,
                           input logic [31:0] b, input logic t, input logic [31:0] xw,
                           input bcdau_pkg::err_t xe);
        stim_row_t r;
        r.op = o; r.bcd = w; r.bin = b; r.typed = t; r.xword = xw; r.xerr = xe;
        rows.push_back(r);
    endtask

    initial
    begin
        bcdau_pkg::op_t o;
        logic [31:0]    w;
        logic [31:0]    b;
        int             k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = bcdau_pkg::OP_CHECK;
        bcd_word = 32'd0;
        binary_operand = 32'd0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 6;
        recv_idle_pct = 68;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        add_row(bcdau_pkg::OP_CHECK, 32'h99999999, 32'd0, 1'b1, 32'h99999999,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_CHECK, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                bcdau_pkg::ERR_DIGIT);
        add_row(bcdau_pkg::OP_CHECK, 32'h0000000A, 32'd0, 1'b1, 32'h0000000A,
                bcdau_pkg::ERR_DIGIT);
        add_row(bcdau_pkg::OP_B2BCD, 32'd0, 32'd99999999, 1'b1, 32'h99999999,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_B2BCD, 32'd0, 32'd100000000, 1'b1, 32'd100000000,
                bcdau_pkg::ERR_RANGE);
        add_row(bcdau_pkg::OP_B2BCD, 32'd0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,
                bcdau_pkg::ERR_RANGE);
        add_row(bcdau_pkg::OP_B2BCD, 32'd0, 32'd0, 1'b1, 32'd0, bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_BCD2B, 32'h99999999, 32'd0, 1'b1, 32'd99999999,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_BCD2B, 32'hA0000000, 32'd0, 1'b1, 32'hA0000000,
                bcdau_pkg::ERR_DIGIT);
        add_row(bcdau_pkg::OP_ADD, 32'h99999999, 32'd1, 1'b1, 32'h99999999,
                bcdau_pkg::ERR_OVER);
        add_row(bcdau_pkg::OP_ADD, 32'h00000001, 32'hFFFFFFFF, 1'b1, 32'h00000001,
                bcdau_pkg::ERR_OVER);
        add_row(bcdau_pkg::OP_ADD, 32'h12345678, 32'd11111111, 1'b0, 32'd0,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_SUB, 32'h00000000, 32'd1, 1'b1, 32'h00000000,
                bcdau_pkg::ERR_UNDER);
        add_row(bcdau_pkg::OP_SUB, 32'h99999999, 32'd99999999, 1'b1, 32'h00000000,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_MUL, 32'h00010000, 32'h00010000, 1'b1, 32'h00010000,
                bcdau_pkg::ERR_OVER);
        add_row(bcdau_pkg::OP_MUL, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_MUL, 32'h00009999, 32'd10001, 1'b0, 32'd0,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_DIV, 32'hFFFFFFFF, 32'd0, 1'b1, 32'hFFFFFFFF,
                bcdau_pkg::ERR_DIVZ);
        add_row(bcdau_pkg::OP_DIV, 32'h99999999, 32'hFFFFFFFF, 1'b1, 32'h00000000,
                bcdau_pkg::ERR_NONE);
        add_row(bcdau_pkg::OP_DIV, 32'h0000000B, 32'd3, 1'b1, 32'h0000000B,
                bcdau_pkg::ERR_DIGIT);
        add_row(bcdau_pkg::OP_MOD, 32'h000000F0, 32'd0, 1'b1, 32'h000000F0,
                bcdau_pkg::ERR_DIGIT);
        add_row(bcdau_pkg::OP_MOD, 32'h00000123, 32'd0, 1'b1, 32'h00000123,
                bcdau_pkg::ERR_DIVZ);
        add_row(bcdau_pkg::OP_MOD, 32'h98765432, 32'd1000, 1'b0, 32'd0,
                bcdau_pkg::ERR_NONE);
        @(negedge clk);
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                bcd_result_t p;
                p = predict_bcd_op(rows[i].op, rows[i].bcd, rows[i].bin);
                if (p.word !== rows[i].xword || p.err !== rows[i].xerr)
                begin
                    $display("%0t: table row %0d expected %h/%0d actual %h/%0d", $time, i,
                             rows[i].xword, rows[i].xerr, p.word, p.err);
                    fail_count++;
                end
            end
            send_request(rows[i].op, rows[i].bcd, rows[i].bin);
        end

        // sender pauses until everything has come back
        in_valid <= 1'b0;
        wait_drained();

        // long receiver hold-off, counted in its own process, while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                int n;
                n = 0;
                while (n < 200)
                begin
                    @(negedge clk);
                    n++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int j = 0; j < 100; j++)
                    send_request(bcdau_pkg::OP_ADD, rand_bcd(7),
                                 32'($urandom_range(999999)));
                in_valid <= 1'b0;
                @(negedge clk);
            end
        join

        // random part, three idling phases
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 6;
            end
            if (n == 2 * N_RANDOM / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            o = bcdau_pkg::op_t'($urandom_range(7));
            k = $urandom_range(9);
            w = (k == 0) ? $urandom() : rand_bcd($urandom_range(1, 8));
            case ($urandom_range(5))
                0: b = $urandom();
                1: b = 32'($urandom_range(9));
                2: b = 32'($urandom_range(99999));
                3: b = decode_bcd(rand_bcd(8)) == 64'd0 ? 32'd0 : 32'(decode_bcd(rand_bcd(8)));
                default: b = 32'($urandom_range(99999999));
            endcase
            send_request(o, w, b);
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // leftover expectations are caught by the drain wait hitting the limit
endmodule
